@@ hw/rtl/status_line_receiver_assert.svh @@
// assertion macros for the status line receiver
// no dependencies; included by the files that carry concurrent checks
`ifndef STATUS_LINE_RECEIVER_ASSERT_SVH
`define STATUS_LINE_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// consequent checked in the same cycle as the antecedent
`define SLR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent checked in the cycle after the antecedent
`define SLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/slr_pkg.sv @@
// shared constants for the status line receiver: character codes,
// record kinds and stream widths; no dependencies
package slr_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int OUT_DATA_W = 32;
    // bits used by the packed result fields in the output tdata
    localparam int OUT_USED_W = 27;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;

    // record kinds carried in tuser
    localparam logic [KIND_W-1:0] KIND_STATE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MALFORMED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 2'd3;

endpackage

@@ hw/rtl/status_line_receiver.sv @@
// status line receiver: gathers received bytes into lines and parses
// state and error records; depends on slr_pkg and status_line_receiver_assert.svh
//
//  channel  dir  payload (lowest bit first)
//  s_axis   in   tdata: rx_byte
//  m_axis   out  tuser: record_kind
//                tdata: power_on, fan_mode, fan_speed, fresh_up,
//                       unit_registered, error_code, zero pad
//
// one byte is taken every cycle while the slave side is not stalled; a line
// result is loaded into the result register as its newline byte leaves the
// input register (the parse logic feeds the result register directly). the
// held-back byte and parse state advance together with the input stage. reset
// is synchronous, active low, and clears line state and both valid bits at
// once. a stalled result register holds the input stage, and the slave side
// stalls only when both registers are full and the result is not taken.
`include "status_line_receiver_assert.svh"

module status_line_receiver #(
    parameter int LINE_LENGTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [slr_pkg::BYTE_W-1:0]         s_axis_tdata,  // rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // power_on, fan_mode, fan_speed, fresh_up, unit_registered, error_code, pad
    output logic [slr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [slr_pkg::KIND_W-1:0]         m_axis_tuser   // record_kind
);
    import slr_pkg::*;

    localparam int CNT_W = $clog2(LINE_LENGTH);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_LENGTH - 1);

    // token positions within a state line
    localparam logic [2:0] FLD_POWER = 3'd1;
    localparam logic [2:0] FLD_MODE  = 3'd2;
    localparam logic [2:0] FLD_SPEED = 3'd3;
    localparam logic [2:0] FLD_FRESH = 3'd4;
    localparam logic [2:0] FLD_REGD  = 3'd5;
    localparam logic [2:0] IDX_MAX   = 3'd6;

    typedef enum logic [2:0] {
        CLS_START, CLS_GOT_S, CLS_GOT_E, CLS_STATE,
        CLS_ERROR, CLS_OTHER, CLS_EMPTY, CLS_STATE_END
    } t_class;

    typedef enum logic [1:0] {
        PH_IDLE, PH_SPACE, PH_DIGITS, PH_STOP
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  value;
        logic        neg;
        logic        nz;
    } t_num;

    typedef struct packed {
        logic        power;
        logic [7:0]  mode;
        logic [7:0]  speed;
        logic        fresh;
        logic        registered;
    } t_fields;

    typedef struct packed {
        t_class      cls;
        logic [2:0]  idx;
        t_num        num;
        t_fields     fld;
    } t_line;

    // one character into the number scanner (whitespace, sign, digits)
    function automatic t_num feed_number(t_num cur, logic [BYTE_W-1:0] c);
        t_num       nx;
        logic       is_digit;
        logic       is_space;
        logic       take;
        logic [7:0] d;
        logic [7:0] t;
        nx       = cur;
        is_digit = (c >= CH_0) && (c <= CH_9);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        take     = 1'b1;
        case (cur.phase)
            PH_SPACE: begin
                if (is_space) begin
                    take = 1'b0;
                end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                    nx.neg   = (c == CH_MINUS);
                    nx.phase = PH_DIGITS;
                    take     = 1'b0;
                end else begin
                    nx.phase = is_digit ? PH_DIGITS : PH_STOP;
                end
            end
            PH_DIGITS: begin
                if (!is_digit) nx.phase = PH_STOP;
            end
            default: begin
            end
        endcase
        d = c - CH_0;
        t = (cur.value << 3) + (cur.value << 1);
        if (take && (nx.phase == PH_DIGITS) && is_digit) begin
            nx.value = nx.neg ? (t - d) : (t + d);
            if (d != 8'd0) nx.nz = 1'b1;
        end
        return nx;
    endfunction

    // store an open token into its field and close it
    function automatic t_line close_token(t_line s);
        t_line n;
        n = s;
        if (s.num.phase != PH_IDLE) begin
            case (s.idx)
                FLD_POWER: n.fld.power      = s.num.nz;
                FLD_MODE:  n.fld.mode       = s.num.value;
                FLD_SPEED: n.fld.speed      = s.num.value;
                FLD_FRESH: n.fld.fresh      = s.num.nz;
                FLD_REGD:  n.fld.registered = s.num.nz;
                default: begin
                end
            endcase
        end
        n.num.phase = PH_IDLE;
        return n;
    endfunction

    // one kept character through the line classifier and tokenizer
    function automatic t_line process_byte(t_line s, logic [BYTE_W-1:0] c);
        t_line n;
        n = s;
        case (s.cls)
            CLS_START: begin
                if (c == CH_S)        n.cls = CLS_GOT_S;
                else if (c == CH_E)   n.cls = CLS_GOT_E;
                else if (c == CH_NUL) n.cls = CLS_EMPTY;
                else                  n.cls = CLS_OTHER;
            end
            CLS_GOT_S: begin
                if (c == CH_COMMA) begin
                    n.cls       = CLS_STATE;
                    n.idx       = 3'd0;
                    n.num.phase = PH_IDLE;
                end else begin
                    n.cls = CLS_OTHER;
                end
            end
            CLS_GOT_E: begin
                if (c == CH_COMMA) begin
                    n.cls = CLS_ERROR;
                    n.num = '{phase: PH_SPACE, value: 8'd0, neg: 1'b0, nz: 1'b0};
                end else begin
                    n.cls = CLS_OTHER;
                end
            end
            CLS_STATE: begin
                if (c == CH_NUL) begin
                    n     = close_token(s);
                    n.cls = CLS_STATE_END;
                end else if (c == CH_COMMA) begin
                    n = close_token(s);
                end else begin
                    if (s.num.phase == PH_IDLE) begin
                        if (s.idx < IDX_MAX) n.idx = s.idx + 3'd1;
                        n.num = '{phase: PH_SPACE, value: 8'd0, neg: 1'b0, nz: 1'b0};
                    end
                    n.num = feed_number(n.num, c);
                end
            end
            CLS_ERROR: begin
                n.num = feed_number(s.num, c);
            end
            default: begin
            end
        endcase
        return n;
    endfunction

    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    t_line                  r_line;
    t_line                  n_line;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_held_valid;
    logic                   n_held_valid;
    logic [BYTE_W-1:0]      r_held_byte;
    logic [BYTE_W-1:0]      n_held_byte;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [KIND_W-1:0]      r_out_kind;
    logic [KIND_W-1:0]      n_out_kind;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic [OUT_DATA_W-1:0]  n_out_data;

    logic   advance;
    logic   fire;
    logic   in_nl;
    logic   room;
    logic   held_en;
    logic   has_result;
    t_line  s_proc;
    t_line  s_close;

    // pipeline flow: the stage moves whenever the result register is free
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign in_nl   = (r_in_byte == CH_LF);
    assign room    = (r_count < CNT_MAX);
    assign held_en = r_held_valid && (in_nl ? (r_held_byte != CH_CR) : room);

    // parse the held byte, then close any open token for the line end
    always_comb begin
        s_proc  = held_en ? process_byte(r_line, r_held_byte) : r_line;
        s_close = close_token(s_proc);
    end

    // result record and next line state
    always_comb begin
        has_result   = 1'b0;
        n_out_kind   = KIND_STATE;
        n_out_data   = '0;
        n_line       = r_line;
        n_count      = r_count;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        case (s_proc.cls)
            CLS_GOT_S, CLS_GOT_E, CLS_OTHER: begin
                has_result = 1'b1;
                n_out_kind = KIND_UNKNOWN;
            end
            CLS_STATE, CLS_STATE_END: begin
                has_result = 1'b1;
                if (s_close.idx >= FLD_REGD) begin
                    n_out_kind = KIND_STATE;
                    n_out_data = {(OUT_DATA_W - OUT_USED_W)'(0), 8'd0,
                                  s_close.fld.registered, s_close.fld.fresh,
                                  s_close.fld.speed, s_close.fld.mode,
                                  s_close.fld.power};
                end else begin
                    n_out_kind = KIND_MALFORMED;
                end
            end
            CLS_ERROR: begin
                has_result = 1'b1;
                n_out_kind = KIND_ERROR;
                n_out_data = {(OUT_DATA_W - OUT_USED_W)'(0), s_proc.num.value, 19'd0};
            end
            default: begin
            end
        endcase
        if (fire) begin
            if (in_nl) begin
                n_line       = '0;
                n_count      = '0;
                n_held_valid = 1'b0;
            end else if (room) begin
                n_line       = s_proc;
                n_count      = r_count + CNT_W'(1);
                n_held_valid = 1'b1;
                n_held_byte  = r_in_byte;
            end
        end
        n_out_valid = advance ? (fire && in_nl && has_result) : r_out_valid;
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line       <= '0;
            r_count      <= '0;
            r_held_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            r_out_valid  <= n_out_valid;
            r_line       <= n_line;
            r_count      <= n_count;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) r_in_byte <= s_axis_tdata;
        r_held_byte <= n_held_byte;
        if (advance) begin
            r_out_kind <= n_out_kind;
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = r_out_data;

    // checks
    `SLR_ASSERT_SAME(a_held_counted, i_clk, i_rst_n, r_held_valid, r_count != '0, "held byte without count")
    `SLR_ASSERT_NEXT(a_line_cleared, i_clk, i_rst_n, fire && in_nl, (r_line.cls == CLS_START) && (r_count == '0) && !r_held_valid, "line state not cleared after newline")
    `SLR_ASSERT_NEXT(a_no_result_mid_line, i_clk, i_rst_n, fire && !in_nl, !m_axis_tvalid, "result produced without newline")
    `SLR_ASSERT_SAME(a_idx_only_in_state, i_clk, i_rst_n, (r_line.cls != CLS_STATE) && (r_line.cls != CLS_STATE_END), r_line.idx == 3'd0, "token index outside state line")

endmodule

@@ dv/slr_record_checker.sv @@
// line record checker for the status line receiver: predicts records from the
// bytes taken on the input stream and compares them with the output stream
// depends on slr_pkg; instantiated by status_line_receiver_test
module slr_record_checker #(
    parameter int LINE_LENGTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [slr_pkg::BYTE_W-1:0]     i_in_data,   // rx_byte
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    // power_on, fan_mode, fan_speed, fresh_up, unit_registered, error_code, pad
    input  logic [slr_pkg::OUT_DATA_W-1:0] i_out_data,
    input  logic [slr_pkg::KIND_W-1:0]     i_out_user,  // record_kind
    output int                             o_fail_count,
    output int                             o_pending
);
    import slr_pkg::*;

    // bit positions of the result fields in the output data
    localparam int POWER_BIT = 0;
    localparam int MODE_LSB  = 1;
    localparam int SPEED_LSB = 9;
    localparam int FRESH_BIT = 17;
    localparam int REG_BIT   = 18;
    localparam int ERROR_LSB = 19;
    localparam int PAD_W     = OUT_DATA_W - OUT_USED_W;
    localparam int REPORT_MAX = 10;

    typedef enum logic [2:0] {
        LC_START, LC_GOT_S, LC_GOT_E, LC_STATE, LC_ERROR, LC_OTHER, LC_EMPTY, LC_STATE_END
    } t_line_class;

    typedef enum logic [1:0] {
        NP_IDLE, NP_SPACE, NP_DIGITS, NP_STOP
    } t_number_phase;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              power_on;
        logic [7:0]        fan_mode;
        logic [7:0]        fan_speed;
        logic              fresh_up;
        logic              registered;
        logic [7:0]        error_code;
        logic [PAD_W-1:0]  pad;
    } t_line_record;

    // predicted line state
    int            kept_count;
    logic          held_valid;
    logic [7:0]    held_char;
    t_line_class   cls;
    int            token_index;
    t_number_phase phase;
    logic [7:0]    acc;
    logic          acc_neg;
    logic          acc_nonzero;
    logic [7:0]    field_vals [5];

    t_line_record  line_records [$];
    int            failures = 0;

    function automatic void clear_number();
        acc = '0;
        acc_neg = 1'b0;
        acc_nonzero = 1'b0;
    endfunction

    function automatic void clear_line();
        kept_count = 0;
        held_valid = 1'b0;
        held_char = '0;
        cls = LC_START;
        token_index = 0;
        phase = NP_IDLE;
        clear_number();
        foreach (field_vals[k]) field_vals[k] = '0;
    endfunction

    // atoi-style accumulation, wrapping at eight bits
    function automatic void accumulate(logic [7:0] c);
        logic       is_digit;
        logic       is_space;
        logic [7:0] d;
        logic [7:0] t;
        is_digit = (c >= CH_0) && (c <= CH_9);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        if (phase == NP_SPACE) begin
            if (is_space) return;
            if (c == CH_PLUS || c == CH_MINUS) begin
                acc_neg = (c == CH_MINUS);
                phase = NP_DIGITS;
                return;
            end
            phase = is_digit ? NP_DIGITS : NP_STOP;
        end else if (phase == NP_DIGITS && !is_digit) begin
            phase = NP_STOP;
        end
        if (phase == NP_DIGITS && is_digit) begin
            d = c - CH_0;
            t = acc * 8'd10;
            acc = acc_neg ? t - d : t + d;
            if (d != 0) acc_nonzero = 1'b1;
        end
    endfunction

    // store the open token into its state field
    function automatic void close_token();
        int k;
        if (phase != NP_IDLE && token_index >= 1 && token_index <= 5) begin
            k = token_index - 1;
            if (k == 0 || k == 3 || k == 4)
                field_vals[k] = {7'd0, acc_nonzero};
            else
                field_vals[k] = acc;
        end
        phase = NP_IDLE;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        case (cls)
            LC_START: begin
                if (c == CH_S)        cls = LC_GOT_S;
                else if (c == CH_E)   cls = LC_GOT_E;
                else if (c == CH_NUL) cls = LC_EMPTY;
                else                  cls = LC_OTHER;
            end
            LC_GOT_S: begin
                if (c == CH_COMMA) begin
                    cls = LC_STATE;
                    token_index = 0;
                    phase = NP_IDLE;
                end else begin
                    cls = LC_OTHER;
                end
            end
            LC_GOT_E: begin
                if (c == CH_COMMA) begin
                    cls = LC_ERROR;
                    phase = NP_SPACE;
                    clear_number();
                end else begin
                    cls = LC_OTHER;
                end
            end
            LC_STATE: begin
                if (c == CH_NUL) begin
                    close_token();
                    cls = LC_STATE_END;
                end else if (c == CH_COMMA) begin
                    close_token();
                end else begin
                    // first byte of a new token
                    if (phase == NP_IDLE) begin
                        if (token_index < 6) token_index++;
                        clear_number();
                        phase = NP_SPACE;
                    end
                    accumulate(c);
                end
            end
            LC_ERROR: accumulate(c);
            default: ;
        endcase
    endfunction

    // newline: drop a held carriage return and queue the line record, if the line has one
    function automatic void finish_line();
        t_line_record rec;
        logic         produce;
        if (held_valid && held_char != CH_CR) parse_char(held_char);
        rec = '0;
        produce = 1'b1;
        case (cls)
            LC_GOT_S, LC_GOT_E, LC_OTHER: rec.kind = KIND_UNKNOWN;
            LC_STATE, LC_STATE_END: begin
                close_token();
                if (token_index >= 5) begin
                    rec.kind = KIND_STATE;
                    rec.power_on = field_vals[0][0];
                    rec.fan_mode = field_vals[1];
                    rec.fan_speed = field_vals[2];
                    rec.fresh_up = field_vals[3][0];
                    rec.registered = field_vals[4][0];
                end else begin
                    rec.kind = KIND_MALFORMED;
                end
            end
            LC_ERROR: begin
                rec.kind = KIND_ERROR;
                rec.error_code = acc;
            end
            default: produce = 1'b0;
        endcase
        if (produce) line_records.push_back(rec);
        clear_line();
    endfunction

    // one byte taken; the last kept byte is held back one step
    function automatic void take_byte(logic [7:0] c);
        if (c == CH_LF) begin
            finish_line();
        end else if (kept_count < LINE_LENGTH - 1) begin
            if (held_valid) parse_char(held_char);
            held_char = c;
            held_valid = 1'b1;
            kept_count++;
        end
    endfunction

    function automatic string record_text(t_line_record r);
        return $sformatf("kind=%0d power=%0b mode=%0d speed=%0d fresh=%0b reg=%0b err=%0d pad=%0h",
                         r.kind, r.power_on, r.fan_mode, r.fan_speed, r.fresh_up,
                         r.registered, r.error_code, r.pad);
    endfunction

    // compare one output transaction with the oldest predicted record
    task automatic check_record();
        t_line_record got;
        t_line_record want;
        got.kind = i_out_user;
        got.power_on = i_out_data[POWER_BIT];
        got.fan_mode = i_out_data[MODE_LSB +: 8];
        got.fan_speed = i_out_data[SPEED_LSB +: 8];
        got.fresh_up = i_out_data[FRESH_BIT];
        got.registered = i_out_data[REG_BIT];
        got.error_code = i_out_data[ERROR_LSB +: 8];
        got.pad = i_out_data[OUT_DATA_W-1:OUT_USED_W];
        if (line_records.size() == 0) begin
            if (failures < REPORT_MAX)
                $display("[%0t] record with no line pending: %s", $realtime, record_text(got));
            failures++;
        end else begin
            want = line_records.pop_front();
            if (got.kind != want.kind || got.power_on != want.power_on ||
                got.fan_mode != want.fan_mode || got.fan_speed != want.fan_speed ||
                got.fresh_up != want.fresh_up || got.registered != want.registered ||
                got.error_code != want.error_code || got.pad != want.pad) begin
                if (failures < REPORT_MAX) begin
                    $display("[%0t] record mismatch", $realtime);
                    $display("  expected %s", record_text(want));
                    $display("  actual   %s", record_text(got));
                end
                failures++;
            end
        end
    endtask

    // watch both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            line_records.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_record();
            if (i_in_valid && i_in_ready) take_byte(i_in_data);
        end
        o_pending <= line_records.size();
        o_fail_count <= failures;
    end

endmodule

@@ dv/status_line_receiver_test.sv @@
// testbench top for the status line receiver: builds directed and random
// received-byte lines, drives both streams with random idling and shows the verdict
// depends on slr_pkg, status_line_receiver and slr_record_checker
module status_line_receiver_test;
    import slr_pkg::*;

    localparam int LINE_LENGTH     = 32;
    localparam int RANDOM_BYTES    = 780;
    localparam int MAX_GAP         = 14;
    localparam int HOLD_OFF_AFTER  = 20;    // records taken before the long hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int STALL_LIMIT     = 2000;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;     // rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // power_on, fan_mode, fan_speed, ...
    logic [KIND_W-1:0]     m_axis_tuser;          // record_kind
    int                    fail_count;
    int                    pending_records;

    logic [BYTE_W-1:0]     line_stream [$];

    status_line_receiver #(
        .LINE_LENGTH(LINE_LENGTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    slr_record_checker #(
        .LINE_LENGTH(LINE_LENGTH)
    ) i_record_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_records)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) line_stream.push_back(s[i]);
    endtask

    task automatic push_line(string s, bit with_cr);
        push_text(s);
        if (with_cr) line_stream.push_back(CH_CR);
        line_stream.push_back(CH_LF);
    endtask

    // one numeric token: optional whitespace, sign, digits and trailing junk
    task automatic push_number();
        int n_digits;
        int k;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                k = $urandom_range(0, 4);
                line_stream.push_back(k == 0 ? CH_SPACE : 8'(CH_TAB + (k == 1 ? 0 : k)));
            end
        end
        k = $urandom_range(0, 5);
        if (k == 0) line_stream.push_back(CH_PLUS);
        else if (k == 1) line_stream.push_back(CH_MINUS);
        if ($urandom_range(0, 19) == 0)
            n_digits = 0;
        else if ($urandom_range(0, 7) == 0)
            n_digits = $urandom_range(4, 8);
        else
            n_digits = $urandom_range(1, 3);
        repeat (n_digits) line_stream.push_back(8'(CH_0 + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) line_stream.push_back(8'($urandom_range(33, 126)));
    endtask

    // mostly well-formed records with random content, the rest broken lines and noise
    task automatic push_random_line();
        int start;
        int pick;
        int n_tokens;
        logic [BYTE_W-1:0] b;
        start = line_stream.size();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // state line, usually five tokens, comma runs now and then
            push_text("S,");
            n_tokens = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 5;
            for (int k = 0; k < n_tokens; k++) begin
                if (k != 0 || $urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 3) : 1)
                        line_stream.push_back(CH_COMMA);
                end
                push_number();
            end
            if ($urandom_range(0, 7) == 0) line_stream.push_back(CH_COMMA);
        end else if (pick < 65) begin
            push_text("E,");
            push_number();
        end else if (pick < 75) begin
            // an S or E prefix or none, then random printable bytes
            case ($urandom_range(0, 2))
                0: line_stream.push_back(CH_S);
                1: line_stream.push_back(CH_E);
                default: ;
            endcase
            repeat ($urandom_range(0, 6)) line_stream.push_back(8'($urandom_range(33, 126)));
        end else if (pick < 87) begin
            // noise over the whole byte range
            repeat ($urandom_range(1, 40)) begin
                b = 8'($urandom_range(0, 255));
                if (b != CH_LF) line_stream.push_back(b);
            end
        end else if (pick < 93) begin
            // overlong line, sometimes with a carriage return in the last kept slot
            push_text("S,");
            repeat (5) begin
                push_number();
                line_stream.push_back(CH_COMMA);
            end
            if ($urandom_range(0, 1) == 0) begin
                while (line_stream.size() - start < LINE_LENGTH - 2)
                    line_stream.push_back(CH_SPACE);
                line_stream.push_back(CH_CR);
            end
            repeat ($urandom_range(5, 30)) line_stream.push_back(8'(CH_0 + $urandom_range(0, 9)));
        end else if (pick < 97) begin
            // zero byte ends the line early
            if ($urandom_range(0, 1) == 0) push_text("S,");
            else push_text("E,");
            push_number();
            line_stream.push_back(CH_NUL);
            push_text(",1,2,3,4");
        end
        // anything else stays an empty line
        push_line("", $urandom_range(0, 3) == 0);
    endtask

    // output side: random ready, one long hold-off while input keeps coming
    initial begin : record_sink
        int taken;
        int gap;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (taken == HOLD_OFF_AFTER)
                gap = HOLD_OFF_CYCLES;
            else
                gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
            @(negedge i_clk);
        end
    end

    // ends the run when no transaction moves for too long
    initial begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // input side: build the byte stream, reset, send, drain, verdict
    initial begin : byte_source
        int gap;
        int directed_len;
        bit quiet;

        // directed lines
        push_line("S,1,2,3,4,5", 1'b1);
        push_line("S,0,255,256,-1,+0", 1'b0);
        push_line("S,,,7,, 12 ,x3,2,-9,8,9", 1'b0);
        push_line("S,1,2,3", 1'b0);
        push_line("S,99999,-129,  +65,00,-0", 1'b0);
        push_line("E,-300", 1'b1);
        push_text("E, ");
        line_stream.push_back(CH_TAB);
        push_line("+17", 1'b0);
        push_line("Sx", 1'b0);
        push_line("E", 1'b0);
        push_line("hello", 1'b0);
        push_line("", 1'b0);
        push_line("", 1'b1);
        push_text("S,1,2");
        line_stream.push_back(CH_NUL);
        push_line("3,4,5", 1'b0);
        line_stream.push_back(CH_NUL);
        push_line("E,5", 1'b0);
        // carriage return in the last kept position of an overlong line
        push_text("E,");
        repeat (LINE_LENGTH - 6) line_stream.push_back(CH_SPACE);
        push_text("42");
        line_stream.push_back(CH_CR);
        push_line("99", 1'b0);
        directed_len = line_stream.size();

        while (line_stream.size() < directed_len + RANDOM_BYTES) push_random_line();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        quiet = 1'b0;
        foreach (line_stream[n]) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
            gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= line_stream[n];
            do @(posedge i_clk); while (!s_axis_tready);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_records == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_records == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
